/* src/rct_pkg.sv */
`timescale 1ns / 1ps

package rct_pkg;

  // request operation codes
  typedef enum logic [1:0] {
    FnRun     = 2'd0,
    FnTrigger = 2'd1,
    FnCancel  = 2'd2,
    FnNone    = 2'd3
  } func_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CfgEnable         = 3'd0,
    CfgAllowRetrigger = 3'd1,
    CfgBothEdges      = 3'd2,
    CfgTriggerLinked  = 3'd3,
    CfgCooldownTime   = 3'd4,
    CfgDurationTime   = 3'd5
  } cfg_idx_e;

  localparam int unsigned TimeW = 32;

  typedef logic [TimeW-1:0] time_t;

  localparam time_t DurationReset = 32'd1000;

endpackage

/* src/retriggerable_countdown_timer_top.sv */
`timescale 1ns / 1ps

// Retriggerable countdown timer. Each request carries an operation (run step with a
// sampled trigger level, software trigger, cancel, or no operation) and the current
// free-running millisecond time; each request returns exactly one result with the
// active flag, the remaining time, the number of accepted triggers and the run
// status. A request is held in the input register and evaluated against the timer
// state on the way into the output register, so the block sustains one request per
// clock while the output is not stalled. The single state update per request (two
// 32-bit subtract-and-compare paths, a subtract and an increment) is the logic
// between the two registers. While a result waits on a stalled output the input
// register takes one more request and then the input stalls. Configuration registers
// are written through a plain write port and must only change while no request is in
// flight; out-of-range indexes are ignored.
module retriggerable_countdown_timer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] now_time_i,
  input  logic        trigger_level_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        is_active_o,
  output logic [31:0] time_left_o,
  output logic [31:0] fire_count_o,
  output logic        run_status_o
);

  // configuration registers
  logic           enable_q;
  logic           allow_retrigger_q;
  logic           both_edges_q;
  logic           trigger_linked_q;
  rct_pkg::time_t cooldown_q;
  rct_pkg::time_t duration_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q          <= 1'b1;
      allow_retrigger_q <= 1'b0;
      both_edges_q      <= 1'b0;
      trigger_linked_q  <= 1'b0;
      cooldown_q        <= '0;
      duration_q        <= rct_pkg::DurationReset;
    end else if (cfg_we_i) begin
      case (rct_pkg::cfg_idx_e'(cfg_index_i))
        rct_pkg::CfgEnable:         enable_q          <= cfg_data_i[0];
        rct_pkg::CfgAllowRetrigger: allow_retrigger_q <= cfg_data_i[0];
        rct_pkg::CfgBothEdges:      both_edges_q      <= cfg_data_i[0];
        rct_pkg::CfgTriggerLinked:  trigger_linked_q  <= cfg_data_i[0];
        rct_pkg::CfgCooldownTime:   cooldown_q        <= cfg_data_i;
        rct_pkg::CfgDurationTime:   duration_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake: output register advances when empty or not stalled
  logic s1_valid_q;
  logic out_valid_q;
  logic out_ready;
  logic s1_move;
  logic in_accept;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  // input register
  rct_pkg::func_e s1_func_q;
  rct_pkg::time_t s1_now_q;
  logic           s1_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_func_q  <= rct_pkg::func_e'(func_i);
      s1_now_q   <= now_time_i;
      s1_level_q <= trigger_level_i;
    end
  end

  // timer state
  logic           last_level_q, last_level_d;
  logic           running_q, running_d;
  rct_pkg::time_t start_q, start_d;
  rct_pkg::time_t last_fire_q, last_fire_d;
  rct_pkg::time_t count_q, count_d;
  rct_pkg::time_t remaining_q, remaining_d;

  logic           edge_seen;
  logic           fire_req;
  logic           cool_block;
  logic           fire_ok;
  rct_pkg::time_t since_fire;
  rct_pkg::time_t elapsed;

  assign edge_seen  = (s1_level_q && !last_level_q) ||
                      (both_edges_q && !s1_level_q && last_level_q);
  assign fire_req   = (s1_func_q == rct_pkg::FnTrigger) ||
                      ((s1_func_q == rct_pkg::FnRun) && trigger_linked_q && edge_seen);
  assign since_fire = s1_now_q - last_fire_q;
  // first trigger (or first after count wrap) skips the cooldown guard
  assign cool_block = (count_q != '0) && (cooldown_q != '0) && (since_fire < cooldown_q);
  assign fire_ok    = fire_req && enable_q && !cool_block &&
                      !(running_q && !allow_retrigger_q);
  assign elapsed    = s1_now_q - start_q;

  always_comb begin
    last_level_d = last_level_q;
    running_d    = running_q;
    start_d      = start_q;
    last_fire_d  = last_fire_q;
    count_d      = count_q;
    remaining_d  = remaining_q;

    if (fire_ok) begin
      running_d   = 1'b1;
      start_d     = s1_now_q;
      last_fire_d = s1_now_q;
      count_d     = count_q + 32'd1;
    end

    case (s1_func_q)
      rct_pkg::FnRun: begin
        last_level_d = s1_level_q;
        if (fire_ok) begin
          // fresh start: nothing elapsed yet
          if (duration_q == '0) begin
            running_d   = 1'b0;
            remaining_d = '0;
          end else begin
            remaining_d = duration_q;
          end
        end else if (running_q) begin
          if (elapsed >= duration_q) begin
            running_d   = 1'b0;
            remaining_d = '0;
          end else begin
            remaining_d = duration_q - elapsed;
          end
        end
      end
      rct_pkg::FnCancel: begin
        running_d   = 1'b0;
        remaining_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q <= 1'b0;
      running_q    <= 1'b0;
      start_q      <= '0;
      last_fire_q  <= '0;
      count_q      <= '0;
      remaining_q  <= '0;
    end else if (s1_move) begin
      last_level_q <= last_level_d;
      running_q    <= running_d;
      start_q      <= start_d;
      last_fire_q  <= last_fire_d;
      count_q      <= count_d;
      remaining_q  <= remaining_d;
    end
  end

  // result register
  logic           res_active_q;
  rct_pkg::time_t res_left_q;
  rct_pkg::time_t res_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      res_active_q <= running_d;
      res_left_q   <= remaining_d;
      res_count_q  <= count_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign is_active_o  = res_active_q;
  assign time_left_o  = res_left_q;
  assign fire_count_o = res_count_q;
  // status follows the running flag for every operation
  assign run_status_o = res_active_q;

  // idle timer always reports zero remaining time
  a_idle_zero_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> (remaining_q == '0))
    else $error("remaining time nonzero while idle");

  // trigger count moves by at most one per request
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 ((count_q == $past(count_q)) || (count_q == $past(count_q) + 32'd1)))
    else $error("trigger count jumped");

  // a disabled timer never accepts a trigger
  a_disabled_no_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !enable_q |=> (count_q == $past(count_q)))
    else $error("trigger accepted while disabled");

  // input only stalls when the input register holds a request
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with free input register");

endmodule

/* tb/sv/retriggerable_countdown_timer_top_tb.sv */
`timescale 1ns / 1ps

module retriggerable_countdown_timer_top_tb;

  // long receiver hold-off and the no-progress limit, in cycles
  localparam int HoldCycles    = 120;
  localparam int WatchdogLimit = 2000;
  localparam int RandomPhases  = 8;
  localparam int PhaseRequests = 138;

  typedef struct packed {
    rct_pkg::func_e fn;
    rct_pkg::time_t now;
    logic           level;
  } timer_req_t;

  typedef struct packed {
    logic           active;
    rct_pkg::time_t left;
    rct_pkg::time_t fires;
    logic           status;
  } timer_status_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  func_i = '0;
  logic [31:0] now_time_i = '0;
  logic        trigger_level_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        is_active_o;
  logic [31:0] time_left_o;
  logic [31:0] fire_count_o;
  logic        run_status_o;

  retriggerable_countdown_timer_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .now_time_i     (now_time_i),
    .trigger_level_i(trigger_level_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .is_active_o    (is_active_o),
    .time_left_o    (time_left_o),
    .fire_count_o   (fire_count_o),
    .run_status_o   (run_status_o)
  );

  // 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // requests waiting to be offered, and status words the block still owes us
  timer_req_t    request_q[$];
  timer_status_t pending_status_q[$];

  // traffic knobs, only changed on the falling edge; hold_cnt counts on the rising edge
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          press_on = 1'b0;
  int          hold_cnt = 0;

  int err_cnt = 0;
  int checked_cnt = 0;
  int accepted_cnt = 0;
  int expired_cnt = 0;
  int idle_cycles = 0;

  // our copy of the register file, starting from reset values
  logic           cfg_enable = 1'b1;
  logic           cfg_retrigger = 1'b0;
  logic           cfg_both_edges = 1'b0;
  logic           cfg_linked = 1'b0;
  rct_pkg::time_t cfg_cooldown = '0;
  rct_pkg::time_t cfg_duration = rct_pkg::DurationReset;

  // our copy of the timer state
  logic           prev_level = 1'b0;
  logic           counting = 1'b0;
  rct_pkg::time_t start_ms = '0;
  rct_pkg::time_t last_fire_ms = '0;
  rct_pkg::time_t fire_total = '0;
  rct_pkg::time_t left_ms = '0;

  // trigger acceptance: enable, then cooldown guard, then retrigger rule
  function automatic void try_fire(input rct_pkg::time_t now);
    rct_pkg::time_t since_fire;
    since_fire = now - last_fire_ms;
    if (!cfg_enable) return;
    // the very first trigger (or the first after the count wraps) skips the guard
    if (fire_total != '0 && cfg_cooldown != '0 && since_fire < cfg_cooldown) return;
    if (counting && !cfg_retrigger) return;
    start_ms     = now;
    last_fire_ms = now;
    counting     = 1'b1;
    fire_total   = fire_total + 1;
  endfunction

  // one request through the timer, queueing the status word it yields
  function automatic void advance_timer(input rct_pkg::func_e fn, input rct_pkg::time_t now,
                                        input logic level);
    rct_pkg::time_t elapsed;
    timer_status_t  st;
    case (fn)
      rct_pkg::FnRun: begin
        // edges are taken against the last sample even while unlinked
        if (cfg_linked && ((level && !prev_level) || (cfg_both_edges && !level && prev_level)))
          try_fire(now);
        prev_level = level;
        if (counting) begin
          elapsed = now - start_ms;
          if (elapsed >= cfg_duration) begin
            counting    = 1'b0;
            left_ms     = '0;
            expired_cnt++;
          end else begin
            left_ms = cfg_duration - elapsed;
          end
        end
      end
      // software trigger leaves the remaining time as the last run step left it
      rct_pkg::FnTrigger: try_fire(now);
      rct_pkg::FnCancel: begin
        counting = 1'b0;
        left_ms  = '0;
      end
      default: ;
    endcase
    st.active = counting;
    st.left   = left_ms;
    st.fires  = fire_total;
    st.status = counting;
    pending_status_q.push_back(st);
  endfunction

  // request driver: predicts on acceptance, then offers the next request or idles
  always @(posedge clk_i) begin
    timer_req_t r;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        advance_timer(rct_pkg::func_e'(func_i), now_time_i, trigger_level_i);
        accepted_cnt++;
      end
      // a stalled request stays put; otherwise pick the next one or go idle
      if (!in_valid_i || !in_stall_o) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          r = request_q.pop_front();
          in_valid_i      <= 1'b1;
          func_i          <= r.fn;
          now_time_i      <= r.now;
          trigger_level_i <= r.level;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor: compares each accepted status word with the oldest one owed
  always @(posedge clk_i) begin
    timer_status_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        checked_cnt++;
        if (pending_status_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected result active=%0b left=%0d fires=%0d status=%0b",
                     $realtime, is_active_o, time_left_o, fire_count_o, run_status_o);
        end else begin
          want = pending_status_q.pop_front();
          if (is_active_o !== want.active || time_left_o !== want.left ||
              fire_count_o !== want.fires || run_status_o !== want.status) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("%0t: mismatch exp active=%0b left=%0d fires=%0d status=%0b",
                       $realtime, want.active, want.left, want.fires, want.status);
              $display("%0t:          got active=%0b left=%0d fires=%0d status=%0b",
                       $realtime, is_active_o, time_left_o, fire_count_o, run_status_o);
            end
          end
        end
      end
      // long hold-off while pressure is on, random stalls otherwise
      if (press_on && hold_cnt < HoldCycles) begin
        out_stall_i <= 1'b1;
        hold_cnt    <= hold_cnt + 1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
        if (!press_on) hold_cnt <= 0;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no progress, %0d status words still owed", pending_status_q.size());
      $display("retriggerable_countdown_timer_top test failed");
      $finish;
    end
  end

  // register write, only issued while the block is idle
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      rct_pkg::CfgEnable:         cfg_enable = val[0];
      rct_pkg::CfgAllowRetrigger: cfg_retrigger = val[0];
      rct_pkg::CfgBothEdges:      cfg_both_edges = val[0];
      rct_pkg::CfgTriggerLinked:  cfg_linked = val[0];
      rct_pkg::CfgCooldownTime:   cfg_cooldown = val;
      rct_pkg::CfgDurationTime:   cfg_duration = val;
      default: ;
    endcase
  endtask

  task automatic add_req(input rct_pkg::func_e fn, input rct_pkg::time_t now,
                         input logic level);
    timer_req_t r;
    r.fn    = fn;
    r.now   = now;
    r.level = level;
    request_q.push_back(r);
  endtask

  // wait until every request is in and every status word is out
  task automatic drain();
    do @(negedge clk_i);
    while (request_q.size() != 0 || in_valid_i || pending_status_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    rct_pkg::time_t clock_ms;
    logic           level;
    rct_pkg::func_e fn;
    int unsigned    pick;
    rct_pkg::time_t dur;
    rct_pkg::time_t cool;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset settings, plain countdown, ignored trigger, expiry, time wrap
    add_req(rct_pkg::FnRun, 32'd0, 1'b0);
    add_req(rct_pkg::FnTrigger, 32'd100, 1'b0);
    add_req(rct_pkg::FnRun, 32'd500, 1'b1);
    add_req(rct_pkg::FnTrigger, 32'd600, 1'b0);
    add_req(rct_pkg::FnRun, 32'd1100, 1'b0);
    add_req(rct_pkg::FnTrigger, 32'hFFFF_FF00, 1'b1);
    add_req(rct_pkg::FnRun, 32'h0000_0100, 1'b1);
    add_req(rct_pkg::FnCancel, 32'h0000_0200, 1'b0);
    add_req(rct_pkg::FnNone, 32'hFFFF_FFFF, 1'b1);
    drain();

    // unknown indexes are dropped, one-bit registers keep bit 0 only
    write_reg(3'(rct_pkg::CfgDurationTime) + 3'd1, 32'hFFFF_FFFF);
    write_reg(3'(rct_pkg::CfgDurationTime) + 3'd2, 32'h0000_0000);
    write_reg(rct_pkg::CfgAllowRetrigger, 32'hFFFF_FFFF);
    write_reg(rct_pkg::CfgTriggerLinked, 32'h8000_0001);
    write_reg(rct_pkg::CfgBothEdges, 32'hFFFF_FFFE);
    write_reg(rct_pkg::CfgDurationTime, 32'd0);
    @(negedge clk_i);

    // linked level: stale high is no edge, falling ignored, rise fires, zero duration
    add_req(rct_pkg::FnRun, 32'd10, 1'b1);
    add_req(rct_pkg::FnRun, 32'd20, 1'b0);
    add_req(rct_pkg::FnRun, 32'd30, 1'b1);
    add_req(rct_pkg::FnTrigger, 32'd40, 1'b0);
    add_req(rct_pkg::FnTrigger, 32'd40, 1'b0);
    add_req(rct_pkg::FnRun, 32'd41, 1'b1);
    drain();

    // both edges, cooldown guard, longest duration
    write_reg(rct_pkg::CfgBothEdges, 32'd1);
    write_reg(rct_pkg::CfgCooldownTime, 32'd500);
    write_reg(rct_pkg::CfgDurationTime, 32'hFFFF_FFFF);
    @(negedge clk_i);
    add_req(rct_pkg::FnRun, 32'd1000, 1'b0);
    add_req(rct_pkg::FnTrigger, 32'd1200, 1'b0);
    add_req(rct_pkg::FnRun, 32'd1500, 1'b1);
    add_req(rct_pkg::FnCancel, 32'd1501, 1'b1);
    drain();

    // disabled timer ignores everything
    write_reg(rct_pkg::CfgEnable, 32'hFFFF_FFFE);
    @(negedge clk_i);
    add_req(rct_pkg::FnTrigger, 32'd5000, 1'b0);
    add_req(rct_pkg::FnRun, 32'd6000, 1'b0);
    add_req(rct_pkg::FnNone, 32'd0, 1'b0);
    drain();

    // random phases, each with its own settings and traffic pattern
    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0:       dur = 32'd0;
        1:       dur = 32'hFFFF_FFFF;
        2:       dur = 32'd1;
        default: begin
          pick = $urandom_range(2);
          dur = (pick == 0) ? rct_pkg::DurationReset
                            : rct_pkg::time_t'($urandom_range(2000, 1));
        end
      endcase
      pick = $urandom_range(5);
      case (pick)
        0, 1:    cool = 32'd0;
        2:       cool = $urandom_range(400, 1);
        3:       cool = (p == 4) ? 32'hFFFF_FFFF : 32'd1;
        4:       cool = $urandom;
        default: cool = 32'd1;
      endcase
      if (p == 6) cool = 32'hFFFF_FFFF;
      // upper bits of the one-bit registers are junk on purpose
      write_reg(rct_pkg::CfgEnable, {31'($urandom_range(32'h7FFF_FFFF)), (p != 3)});
      write_reg(rct_pkg::CfgAllowRetrigger, {31'($urandom_range(32'h7FFF_FFFF)), p[0]});
      write_reg(rct_pkg::CfgBothEdges, {31'($urandom_range(32'h7FFF_FFFF)), p[1]});
      write_reg(rct_pkg::CfgTriggerLinked,
                {31'($urandom_range(32'h7FFF_FFFF)), ($urandom_range(3) != 0)});
      write_reg(rct_pkg::CfgCooldownTime, cool);
      write_reg(rct_pkg::CfgDurationTime, dur);
      @(negedge clk_i);

      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      // one phase backs up the block behind a long receiver hold-off
      if (p == 5) begin
        send_idle_pct = 0;
        press_on = 1'b1;
      end

      clock_ms = $urandom;
      level = 1'($urandom_range(1));
      for (int i = 0; i < PhaseRequests; i++) begin
        if ($urandom_range(99) < 85) begin
          // well-formed: time moves forward in small steps, level toggles now and then
          if ($urandom_range(19) == 0) clock_ms = clock_ms + $urandom;
          else clock_ms = clock_ms + $urandom_range(400);
          if ($urandom_range(9) < 3) level = !level;
          pick = $urandom_range(99);
          if (pick < 70) fn = rct_pkg::FnRun;
          else if (pick < 86) fn = rct_pkg::FnTrigger;
          else if (pick < 96) fn = rct_pkg::FnCancel;
          else fn = rct_pkg::FnNone;
          add_req(fn, clock_ms, level);
        end else begin
          // noise: any time, any operation, any level
          add_req(rct_pkg::func_e'($urandom_range(3)), $urandom, 1'($urandom_range(1)));
        end
      end
      drain();
      press_on = 1'b0;
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (10) @(negedge clk_i);

    $display("summary: %0d requests and %0d results over %0d settings, %0d countdowns ran out",
             accepted_cnt, checked_cnt, RandomPhases + 4, expired_cnt);
    $display("summary: %0d mismatches, %0d status words left over",
             err_cnt, pending_status_q.size());
    if (err_cnt == 0 && pending_status_q.size() == 0) begin
      $display("retriggerable_countdown_timer_top test passed");
    end else begin
      $display("retriggerable_countdown_timer_top test failed");
    end
    $finish;
  end

endmodule
